// ----- hdl/mwg_pkg.sv -----
// ----------------------------------------------------------------------------
// mwg_pkg: shared types and constants of the multiscale window generator
// Field widths, register indexes, reset values, controller states and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package mwg_pkg;

  localparam int CoordW         = 12;
  localparam int SizeW          = 20;
  localparam int StepW          = 21;
  localparam int ScaleW         = 16;
  localparam int BaseW          = 12;
  localparam int StrideW        = 9;
  localparam int StrideFracBits = 8;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 18;
  localparam int MulAW          = 20;
  localparam int MulBW          = 16;
  localparam int ProdW          = MulAW + MulBW;
  localparam int AdvW           = 23;

  localparam logic [SizeW-1:0]  SizeMax  = {SizeW{1'b1}};
  localparam logic [ScaleW-1:0] ScaleMax = {ScaleW{1'b1}};

  localparam logic [CoordW-1:0]   ImgWidthRst   = 12'd640;
  localparam logic [CoordW-1:0]   ImgHeightRst  = 12'd480;
  localparam logic [BaseW-1:0]    BaseWidthRst  = 12'd64;
  localparam logic [BaseW-1:0]    BaseHeightRst = 12'd128;
  localparam logic [ScaleW-1:0]   MinScaleRst   = 16'd256;
  localparam logic [ScaleW-1:0]   MaxScaleRst   = 16'd1024;
  localparam logic [ScaleW-1:0]   ScaleStepRst  = 16'd307;
  localparam logic [CfgDataW-1:0] StrideRst     = 18'd65664;

  typedef enum logic [CfgIdxW-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_BASE_WIDTH   = 3'd2,
    REG_BASE_HEIGHT  = 3'd3,
    REG_MIN_SCALE    = 3'd4,
    REG_MAX_SCALE    = 3'd5,
    REG_SCALE_STEP   = 3'd6,
    REG_STRIDE       = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WS_VALID = 2'd0,
    WS_DONE  = 2'd1,
    WS_NONE  = 2'd2
  } win_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_SK_CHK,
    ST_SK_W,
    ST_SK_H,
    ST_SK_SX,
    ST_SK_SY,
    ST_ADV,
    ST_NS_FIX,
    ST_FOUND,
    ST_MISS,
    ST_FINISH
  } ctl_state_t;

  typedef enum logic [2:0] {
    MS_BW,
    MS_BH,
    MS_FX,
    MS_FY,
    MS_STEP
  } mul_sel_t;

  typedef struct packed {
    mul_sel_t mul_sel;
    logic     ld_min_scale;
    logic     ld_next_scale;
    logic     ld_w;
    logic     ld_h;
    logic     ld_sx;
    logic     ld_sy;
    logic     zero_pos;
    logic     adv_pos;
    logic     copy_main;
    logic     commit;
    logic     run_we;
    logic     run_val;
    logic     any_we;
    logic     last_we;
    logic     last_val;
    logic     load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scale_lt_max;
    logic seek_fit;
    logic adv_x_fit;
    logic adv_y_fit;
    logic running;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/mwg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mwg_ctrl: sequencer of the multiscale window generator
// Walks one request through the position advance, the scale search and the
// look-ahead that decides whether the delivered window is the final one.
// ----------------------------------------------------------------------------
module mwg_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_restart,
  input  mwg_pkg::dp_status_t status,
  output mwg_pkg::dp_cmd_t    cmd
);

  mwg_pkg::ctl_state_t state_r, state_nxt;
  logic                peek_r, peek_nxt;
  logic                restart_r, restart_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= mwg_pkg::ST_IDLE;
      peek_r    <= 1'b0;
      restart_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      peek_r    <= peek_nxt;
      restart_r <= restart_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    peek_nxt    = peek_r;
    restart_nxt = restart_r;
    unique case (state_r)
      mwg_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt   = mwg_pkg::ST_START;
          restart_nxt = in_restart;
          peek_nxt    = 1'b0;
        end
      end
      mwg_pkg::ST_START: begin
        if (restart_r) begin
          state_nxt = mwg_pkg::ST_SK_CHK;
        end else if (status.running) begin
          state_nxt = mwg_pkg::ST_ADV;
        end else begin
          state_nxt = mwg_pkg::ST_FINISH;
        end
      end
      mwg_pkg::ST_SK_CHK: begin
        state_nxt = status.scale_lt_max ? mwg_pkg::ST_SK_W : mwg_pkg::ST_MISS;
      end
      mwg_pkg::ST_SK_W:  state_nxt = mwg_pkg::ST_SK_H;
      mwg_pkg::ST_SK_H:  state_nxt = mwg_pkg::ST_SK_SX;
      mwg_pkg::ST_SK_SX: state_nxt = mwg_pkg::ST_SK_SY;
      mwg_pkg::ST_SK_SY: begin
        state_nxt = status.seek_fit ? mwg_pkg::ST_FOUND : mwg_pkg::ST_NS_FIX;
      end
      mwg_pkg::ST_ADV: begin
        if (status.adv_x_fit || status.adv_y_fit) begin
          state_nxt = mwg_pkg::ST_FOUND;
        end else begin
          state_nxt = mwg_pkg::ST_NS_FIX;
        end
      end
      mwg_pkg::ST_NS_FIX: state_nxt = mwg_pkg::ST_SK_CHK;
      mwg_pkg::ST_FOUND: begin
        if (peek_r) begin
          state_nxt = mwg_pkg::ST_FINISH;
        end else begin
          state_nxt = mwg_pkg::ST_ADV;
          peek_nxt  = 1'b1;
        end
      end
      mwg_pkg::ST_MISS: state_nxt = mwg_pkg::ST_FINISH;
      mwg_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = mwg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mwg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mwg_pkg::MS_BW;
    in_ready    = 1'b0;
    unique case (state_r)
      mwg_pkg::ST_IDLE: in_ready = 1'b1;
      mwg_pkg::ST_START: begin
        if (restart_r) begin
          cmd.ld_min_scale = 1'b1;
        end else if (status.running) begin
          cmd.copy_main = 1'b1;
        end
      end
      mwg_pkg::ST_SK_CHK: cmd.mul_sel = mwg_pkg::MS_BW;
      mwg_pkg::ST_SK_W: begin
        cmd.ld_w    = 1'b1;
        cmd.mul_sel = mwg_pkg::MS_BH;
      end
      mwg_pkg::ST_SK_H: begin
        cmd.ld_h    = 1'b1;
        cmd.mul_sel = mwg_pkg::MS_FX;
      end
      mwg_pkg::ST_SK_SX: begin
        cmd.ld_sx   = 1'b1;
        cmd.mul_sel = mwg_pkg::MS_FY;
      end
      mwg_pkg::ST_SK_SY: begin
        cmd.ld_sy    = 1'b1;
        cmd.zero_pos = status.seek_fit;
        cmd.mul_sel  = mwg_pkg::MS_STEP;
      end
      mwg_pkg::ST_ADV: begin
        cmd.adv_pos = 1'b1;
        cmd.mul_sel = mwg_pkg::MS_STEP;
      end
      mwg_pkg::ST_NS_FIX: cmd.ld_next_scale = 1'b1;
      mwg_pkg::ST_FOUND: begin
        if (peek_r) begin
          cmd.last_we  = 1'b1;
          cmd.last_val = 1'b0;
        end else begin
          cmd.commit  = 1'b1;
          cmd.run_we  = 1'b1;
          cmd.run_val = 1'b1;
          cmd.any_we  = restart_r;
        end
      end
      mwg_pkg::ST_MISS: begin
        if (peek_r) begin
          cmd.last_we  = 1'b1;
          cmd.last_val = 1'b1;
        end else begin
          cmd.run_we  = 1'b1;
          cmd.run_val = 1'b0;
          cmd.any_we  = restart_r;
        end
      end
      mwg_pkg::ST_FINISH: cmd.load_out = status.out_free;
      default: in_ready = 1'b0;
    endcase
  end

endmodule

// ----- hdl/mwg_datapath.sv -----
// ----------------------------------------------------------------------------
// mwg_datapath: registers and arithmetic of the multiscale window generator
// Holds the configuration, the delivered window, a working copy for the
// search, one shared registered multiplier and the result register.
// ----------------------------------------------------------------------------
module mwg_datapath #(
  parameter int SCALE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [mwg_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [mwg_pkg::CfgDataW-1:0]        cfg_data,
  input  mwg_pkg::dp_cmd_t                    cmd,
  output mwg_pkg::dp_status_t                 status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mwg_pkg::CoordW-1:0]          out_win_x,
  output logic [mwg_pkg::CoordW-1:0]          out_win_y,
  output logic [mwg_pkg::SizeW-1:0]           out_win_w,
  output logic [mwg_pkg::SizeW-1:0]           out_win_h,
  output logic [1:0]                          out_status,
  output logic                                out_last
);

  localparam int CoordW = mwg_pkg::CoordW;
  localparam int SizeW  = mwg_pkg::SizeW;
  localparam int StepW  = mwg_pkg::StepW;
  localparam int ScaleW = mwg_pkg::ScaleW;
  localparam int BaseW  = mwg_pkg::BaseW;
  localparam int ProdW  = mwg_pkg::ProdW;
  localparam int AdvW   = mwg_pkg::AdvW;
  localparam int MulAW  = mwg_pkg::MulAW;
  localparam int MulBW  = mwg_pkg::MulBW;
  localparam int StrW   = mwg_pkg::StrideW;

  logic [CoordW-1:0]           img_w_r, img_h_r;
  logic [BaseW-1:0]            base_w_r, base_h_r;
  logic [ScaleW-1:0]           min_scale_r, max_scale_r, scale_step_r;
  logic [mwg_pkg::CfgDataW-1:0] stride_r;

  logic [ScaleW-1:0] scale_r, m_scale_r;
  logic [SizeW-1:0]  w_r, h_r, m_w_r, m_h_r;
  logic [StepW-1:0]  sx_r, sy_r, m_sx_r, m_sy_r;
  logic [CoordW-1:0] px_r, py_r, m_px_r, m_py_r;
  logic              running_r, any_r, last_r;

  logic [MulAW-1:0]  mul_a;
  logic [MulBW-1:0]  mul_b;
  logic [ProdW-1:0]  prod_r;
  logic [ProdW-1:0]  prod_scaled, prod_stride;
  logic [SizeW-1:0]  size_sat;
  logic [StepW-1:0]  step_clamp;
  logic [ScaleW-1:0] scale_sat, scale_nxt;
  logic [AdvW-1:0]   nx, ny, x_end, y_end;
  logic              x_fit, y_fit;

  logic              out_valid_r;
  logic [CoordW-1:0] out_x_r, out_y_r;
  logic [SizeW-1:0]  out_w_r, out_h_r;
  logic [1:0]        out_status_r;
  logic              out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r      <= mwg_pkg::ImgWidthRst;
      img_h_r      <= mwg_pkg::ImgHeightRst;
      base_w_r     <= mwg_pkg::BaseWidthRst;
      base_h_r     <= mwg_pkg::BaseHeightRst;
      min_scale_r  <= mwg_pkg::MinScaleRst;
      max_scale_r  <= mwg_pkg::MaxScaleRst;
      scale_step_r <= mwg_pkg::ScaleStepRst;
      stride_r     <= mwg_pkg::StrideRst;
    end else if (cfg_we) begin
      unique case (mwg_pkg::cfg_idx_t'(cfg_index))
        mwg_pkg::REG_IMAGE_WIDTH:  img_w_r      <= cfg_data[CoordW-1:0];
        mwg_pkg::REG_IMAGE_HEIGHT: img_h_r      <= cfg_data[CoordW-1:0];
        mwg_pkg::REG_BASE_WIDTH:   base_w_r     <= cfg_data[BaseW-1:0];
        mwg_pkg::REG_BASE_HEIGHT:  base_h_r     <= cfg_data[BaseW-1:0];
        mwg_pkg::REG_MIN_SCALE:    min_scale_r  <= cfg_data[ScaleW-1:0];
        mwg_pkg::REG_MAX_SCALE:    max_scale_r  <= cfg_data[ScaleW-1:0];
        mwg_pkg::REG_SCALE_STEP:   scale_step_r <= cfg_data[ScaleW-1:0];
        mwg_pkg::REG_STRIDE:       stride_r     <= cfg_data;
      endcase
    end
  end

  always_comb begin
    unique case (cmd.mul_sel)
      mwg_pkg::MS_BW: begin
        mul_a = MulAW'(scale_r);
        mul_b = MulBW'(base_w_r);
      end
      mwg_pkg::MS_BH: begin
        mul_a = MulAW'(scale_r);
        mul_b = MulBW'(base_h_r);
      end
      mwg_pkg::MS_FX: begin
        mul_a = w_r;
        mul_b = MulBW'(stride_r[StrW-1:0]);
      end
      mwg_pkg::MS_FY: begin
        mul_a = h_r;
        mul_b = MulBW'(stride_r[2*StrW-1:StrW]);
      end
      mwg_pkg::MS_STEP: begin
        mul_a = MulAW'(scale_r);
        mul_b = scale_step_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= ProdW'(mul_a) * ProdW'(mul_b);
  end

  assign prod_scaled = prod_r >> SCALE_FRAC_BITS;
  assign prod_stride = prod_r >> mwg_pkg::StrideFracBits;
  assign size_sat    = (prod_scaled > ProdW'(mwg_pkg::SizeMax)) ? mwg_pkg::SizeMax
                                                                : prod_scaled[SizeW-1:0];
  assign step_clamp  = (prod_stride == '0) ? StepW'(1) : prod_stride[StepW-1:0];
  assign scale_sat   = (prod_scaled > ProdW'(mwg_pkg::ScaleMax)) ? mwg_pkg::ScaleMax
                                                                 : prod_scaled[ScaleW-1:0];

  always_comb begin
    if (scale_sat > scale_r) begin
      scale_nxt = scale_sat;
    end else if (scale_r != mwg_pkg::ScaleMax) begin
      scale_nxt = scale_r + ScaleW'(1);
    end else begin
      scale_nxt = mwg_pkg::ScaleMax;
    end
  end

  assign nx    = AdvW'(px_r) + AdvW'(sx_r);
  assign ny    = AdvW'(py_r) + AdvW'(sy_r);
  assign x_end = nx + AdvW'(w_r);
  assign y_end = ny + AdvW'(h_r);
  assign x_fit = x_end < AdvW'(img_w_r);
  assign y_fit = y_end < AdvW'(img_h_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_min_scale) begin
      scale_r <= min_scale_r;
    end else if (cmd.ld_next_scale) begin
      scale_r <= scale_nxt;
    end else if (cmd.copy_main) begin
      scale_r <= m_scale_r;
    end

    if (cmd.ld_w) begin
      w_r <= size_sat;
    end else if (cmd.copy_main) begin
      w_r <= m_w_r;
    end

    if (cmd.ld_h) begin
      h_r <= size_sat;
    end else if (cmd.copy_main) begin
      h_r <= m_h_r;
    end

    if (cmd.ld_sx) begin
      sx_r <= step_clamp;
    end else if (cmd.copy_main) begin
      sx_r <= m_sx_r;
    end

    if (cmd.ld_sy) begin
      sy_r <= step_clamp;
    end else if (cmd.copy_main) begin
      sy_r <= m_sy_r;
    end

    if (cmd.zero_pos) begin
      px_r <= '0;
      py_r <= '0;
    end else if (cmd.adv_pos) begin
      px_r <= x_fit ? nx[CoordW-1:0] : '0;
      if (!x_fit && y_fit) begin
        py_r <= ny[CoordW-1:0];
      end
    end else if (cmd.copy_main) begin
      px_r <= m_px_r;
      py_r <= m_py_r;
    end

    if (cmd.commit) begin
      m_scale_r <= scale_r;
      m_w_r     <= w_r;
      m_h_r     <= h_r;
      m_sx_r    <= sx_r;
      m_sy_r    <= sy_r;
      m_px_r    <= px_r;
      m_py_r    <= py_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r   <= 1'b0;
      any_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.run_we) begin
        running_r <= cmd.run_val;
      end
      if (cmd.any_we) begin
        any_r <= cmd.run_val;
      end
      if (cmd.last_we) begin
        last_r <= cmd.last_val;
      end
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (running_r) begin
        out_x_r      <= m_px_r;
        out_y_r      <= m_py_r;
        out_w_r      <= m_w_r;
        out_h_r      <= m_h_r;
        out_status_r <= mwg_pkg::WS_VALID;
        out_last_r   <= last_r;
      end else begin
        out_x_r      <= '0;
        out_y_r      <= '0;
        out_w_r      <= '0;
        out_h_r      <= '0;
        out_status_r <= any_r ? mwg_pkg::WS_DONE : mwg_pkg::WS_NONE;
        out_last_r   <= 1'b0;
      end
    end
  end

  assign status.scale_lt_max = scale_r < max_scale_r;
  assign status.seek_fit     = (w_r < SizeW'(img_w_r)) && (h_r < SizeW'(img_h_r));
  assign status.adv_x_fit    = x_fit;
  assign status.adv_y_fit    = y_fit;
  assign status.running      = running_r;
  assign status.out_free     = !out_valid_r || out_ready;

  assign out_valid  = out_valid_r;
  assign out_win_x  = out_x_r;
  assign out_win_y  = out_y_r;
  assign out_win_w  = out_w_r;
  assign out_win_h  = out_h_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

endmodule

// ----- hdl/multiscale_window_generator_top.sv -----
// ----------------------------------------------------------------------------
// multiscale_window_generator_top: sliding windows over a scale pyramid
// One request at a time. An advance within a scale steps the position and then
// looks ahead to set last; the next input beat is taken once the result is loaded.
// A restart runs the scale search from the minimum scale; each scale change or
// skipped scale runs it again, in the walk as in the look-ahead that sets last.
// An advance with no window held goes straight to the result. A result still
// waiting holds off the input. Reset loads the default configuration and holds no window.
// ----------------------------------------------------------------------------
module multiscale_window_generator_top #(
  parameter int SCALE_FRAC_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [mwg_pkg::CoordW-1:0]   out_win_x,
  output logic [mwg_pkg::CoordW-1:0]   out_win_y,
  output logic [mwg_pkg::SizeW-1:0]    out_win_w,
  output logic [mwg_pkg::SizeW-1:0]    out_win_h,
  output logic [1:0]                   out_status,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mwg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mwg_pkg::CfgDataW-1:0] cfg_data
);

  mwg_pkg::dp_cmd_t    cmd;
  mwg_pkg::dp_status_t status;

  assign cfg_ready = 1'b1;

  mwg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .status     (status),
    .cmd        (cmd)
  );

  mwg_datapath #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_win_x  (out_win_x),
    .out_win_y  (out_win_y),
    .out_win_w  (out_win_w),
    .out_win_h  (out_win_h),
    .out_status (out_status),
    .out_last   (out_last)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a beat");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != mwg_pkg::WS_VALID) |->
      (out_win_x == '0) && (out_win_y == '0) && (out_win_w == '0) &&
      (out_win_h == '0) && !out_last)
    else $error("result without a window carries nonzero fields");

  a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_status == mwg_pkg::WS_VALID)
    else $error("last flag set on a result without a window");
`endif

endmodule

// ----- sim/multiscale_window_generator_top_test.sv -----
// ----------------------------------------------------------------------------
// multiscale_window_generator_top_test: self-checking bench of the window walk
// A short table of directed requests and register writes, some with the window
// typed in, then random register settings, each followed by runs of restart
// and advance requests. The expected windows come from a behavioral copy of the
// scale pyramid walk. Both handshakes idle at random, and the result side
// holds off once for a long stretch.
// ----------------------------------------------------------------------------
module multiscale_window_generator_top_test;

  localparam int CoordW        = mwg_pkg::CoordW;
  localparam int SizeW         = mwg_pkg::SizeW;
  localparam int StepW         = mwg_pkg::StepW;
  localparam int ScaleW        = mwg_pkg::ScaleW;
  localparam int BaseW         = mwg_pkg::BaseW;
  localparam int StrideW       = mwg_pkg::StrideW;
  localparam int CfgDataW      = mwg_pkg::CfgDataW;
  localparam int FracBits      = 8;
  localparam int QuietCycles   = 8;
  localparam int TailCycles    = 40;
  localparam int HoldCycles    = 400;
  localparam int PhaseItems    = 210;
  localparam int CycleLimit    = 3000000;

  typedef struct packed {
    logic [CoordW-1:0]   x;
    logic [CoordW-1:0]   y;
    logic [SizeW-1:0]    w;
    logic [SizeW-1:0]    h;
    mwg_pkg::win_status_t st;
    logic                last;
  } window_t;

  typedef struct packed {
    logic [ScaleW-1:0] scale;
    logic [SizeW-1:0]  w;
    logic [SizeW-1:0]  h;
    logic [StepW-1:0]  sx;
    logic [StepW-1:0]  sy;
    logic [CoordW-1:0] px;
    logic [CoordW-1:0] py;
  } walk_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct packed {
    row_kind_t           kind;
    mwg_pkg::cfg_idx_t   idx;
    logic [CfgDataW-1:0] data;
    logic                restart;
    logic                typed;
    window_t             want;
  } plan_row_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                in_restart = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [CoordW-1:0]   out_win_x;
  logic [CoordW-1:0]   out_win_y;
  logic [SizeW-1:0]    out_win_w;
  logic [SizeW-1:0]    out_win_h;
  logic [1:0]          out_status;
  logic                out_last;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  mwg_pkg::cfg_idx_t   cfg_index = mwg_pkg::REG_IMAGE_WIDTH;
  logic [CfgDataW-1:0] cfg_data = '0;

  logic [CoordW-1:0]   img_w = mwg_pkg::ImgWidthRst;
  logic [CoordW-1:0]   img_h = mwg_pkg::ImgHeightRst;
  logic [BaseW-1:0]    base_w = mwg_pkg::BaseWidthRst;
  logic [BaseW-1:0]    base_h = mwg_pkg::BaseHeightRst;
  logic [ScaleW-1:0]   scale_lo = mwg_pkg::MinScaleRst;
  logic [ScaleW-1:0]   scale_hi = mwg_pkg::MaxScaleRst;
  logic [ScaleW-1:0]   scale_mul = mwg_pkg::ScaleStepRst;
  logic [CfgDataW-1:0] stride_cfg = mwg_pkg::StrideRst;

  walk_t   walk = '0;
  logic    walk_live = 1'b0;
  logic    walk_hit = 1'b0;

  window_t window_q[$];
  int      mismatches = 0;
  int      cycle_count = 0;
  int      send_idle = 33;
  int      recv_idle = 79;
  int      hold_asks = 0;
  int      hold_seen = 0;
  int      hold_left = 0;

  multiscale_window_generator_top #(
    .SCALE_FRAC_BITS(FracBits)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_restart(in_restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_win_x(out_win_x),
    .out_win_y(out_win_y),
    .out_win_w(out_win_w),
    .out_win_h(out_win_h),
    .out_status(out_status),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic logic [SizeW-1:0] scaled_size(logic [BaseW-1:0] base,
                                                   logic [ScaleW-1:0] s);
    longint unsigned v;
    v = (longint'(base) * longint'(s)) >> FracBits;
    return (v > mwg_pkg::SizeMax) ? mwg_pkg::SizeMax : v[SizeW-1:0];
  endfunction

  function automatic logic [StepW-1:0] stride_step(logic [StrideW-1:0] frac,
                                                   logic [SizeW-1:0] size);
    longint unsigned v;
    v = (longint'(frac) * longint'(size)) >> mwg_pkg::StrideFracBits;
    return (v == 0) ? StepW'(1) : v[StepW-1:0];
  endfunction

  function automatic logic [ScaleW-1:0] grown_scale(logic [ScaleW-1:0] s);
    longint unsigned v;
    v = (longint'(s) * longint'(scale_mul)) >> FracBits;
    if (v > mwg_pkg::ScaleMax) v = mwg_pkg::ScaleMax;
    if (v <= s) v = (s < mwg_pkg::ScaleMax) ? longint'(s) + 1 : longint'(mwg_pkg::ScaleMax);
    return v[ScaleW-1:0];
  endfunction

  function automatic logic find_scale(inout walk_t g);
    while (g.scale < scale_hi) begin
      g.w = scaled_size(base_w, g.scale);
      g.h = scaled_size(base_h, g.scale);
      g.sx = stride_step(stride_cfg[8:0], g.w);
      g.sy = stride_step(stride_cfg[17:9], g.h);
      if (g.w < img_w && g.h < img_h) begin
        g.px = '0;
        g.py = '0;
        return 1'b1;
      end
      g.scale = grown_scale(g.scale);
    end
    return 1'b0;
  endfunction

  function automatic logic step_on(inout walk_t g);
    longint unsigned nx;
    longint unsigned ny;
    nx = longint'(g.px) + longint'(g.sx);
    if (nx + g.w < img_w) begin
      g.px = nx[CoordW-1:0];
      return 1'b1;
    end
    g.px = '0;
    ny = longint'(g.py) + longint'(g.sy);
    if (ny + g.h < img_h) begin
      g.py = ny[CoordW-1:0];
      return 1'b1;
    end
    g.scale = grown_scale(g.scale);
    return find_scale(g);
  endfunction

  function automatic window_t next_window(logic restart);
    walk_t   peek;
    window_t r;
    if (restart) begin
      walk.scale = scale_lo;
      walk_live = find_scale(walk);
      walk_hit = walk_live;
    end else if (walk_live) begin
      walk_live = step_on(walk);
    end
    r = '0;
    if (walk_live) begin
      peek = walk;
      r.x = walk.px;
      r.y = walk.py;
      r.w = walk.w;
      r.h = walk.h;
      r.st = mwg_pkg::WS_VALID;
      r.last = !step_on(peek);
    end else begin
      r.st = walk_hit ? mwg_pkg::WS_DONE : mwg_pkg::WS_NONE;
    end
    return r;
  endfunction

  function automatic void apply_reg(mwg_pkg::cfg_idx_t idx, logic [CfgDataW-1:0] d);
    case (idx)
      mwg_pkg::REG_IMAGE_WIDTH:  img_w = d[CoordW-1:0];
      mwg_pkg::REG_IMAGE_HEIGHT: img_h = d[CoordW-1:0];
      mwg_pkg::REG_BASE_WIDTH:   base_w = d[BaseW-1:0];
      mwg_pkg::REG_BASE_HEIGHT:  base_h = d[BaseW-1:0];
      mwg_pkg::REG_MIN_SCALE:    scale_lo = d[ScaleW-1:0];
      mwg_pkg::REG_MAX_SCALE:    scale_hi = d[ScaleW-1:0];
      mwg_pkg::REG_SCALE_STEP:   scale_mul = d[ScaleW-1:0];
      mwg_pkg::REG_STRIDE:       stride_cfg = d;
      default: begin
      end
    endcase
  endfunction

  function automatic plan_row_t cfg_row(mwg_pkg::cfg_idx_t idx, int d);
    plan_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.idx = idx;
    r.data = CfgDataW'(d);
    return r;
  endfunction

  function automatic plan_row_t req(logic restart);
    plan_row_t r;
    r = '0;
    r.kind = ROW_REQ;
    r.restart = restart;
    return r;
  endfunction

  function automatic plan_row_t req_is(logic restart, int x, int y, int w, int h,
                                       mwg_pkg::win_status_t st, logic last);
    plan_row_t r;
    r = req(restart);
    r.typed = 1'b1;
    r.want.x = CoordW'(x);
    r.want.y = CoordW'(y);
    r.want.w = SizeW'(w);
    r.want.h = SizeW'(h);
    r.want.st = st;
    r.want.last = last;
    return r;
  endfunction

  function automatic logic [CoordW-1:0] image_extent();
    return ($urandom_range(0, 1) == 0) ? CoordW'($urandom_range(0, 48))
                                       : CoordW'($urandom_range(1, 4095));
  endfunction

  function automatic logic [BaseW-1:0] window_base();
    return ($urandom_range(0, 1) == 0) ? BaseW'($urandom_range(0, 24))
                                       : BaseW'($urandom);
  endfunction

  task automatic settle();
    in_valid <= 1'b0;
    while (window_q.size() != 0) @(posedge clk);
    repeat (QuietCycles) @(posedge clk);
  endtask

  task automatic write_reg(mwg_pkg::cfg_idx_t idx, logic [CfgDataW-1:0] d);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic restart, output window_t guess);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    guess = next_window(restart);
  endtask

  task automatic pick_setting();
    logic [ScaleW-1:0] lo;
    logic [ScaleW-1:0] hi;
    logic [ScaleW-1:0] mul;
    if ($urandom_range(0, 3) == 0) begin
      mul = ScaleW'($urandom_range(257, 383));
      lo = ScaleW'($urandom_range(200, 250));
      hi = lo + ScaleW'($urandom_range(0, 48));
    end else begin
      mul = ScaleW'($urandom_range(384, 65535));
      lo = ($urandom_range(0, 7) == 0) ? ScaleW'($urandom) : ScaleW'($urandom_range(0, 1024));
      hi = ($urandom_range(0, 7) == 0) ? ScaleW'($urandom)
                                       : lo + ScaleW'($urandom_range(0, 2048));
    end
    if ($urandom_range(0, 3) != 0)
      write_reg(mwg_pkg::REG_IMAGE_WIDTH, {6'($urandom), image_extent()});
    if ($urandom_range(0, 3) != 0)
      write_reg(mwg_pkg::REG_IMAGE_HEIGHT, {6'($urandom), image_extent()});
    if ($urandom_range(0, 3) != 0)
      write_reg(mwg_pkg::REG_BASE_WIDTH, {6'($urandom), window_base()});
    if ($urandom_range(0, 3) != 0)
      write_reg(mwg_pkg::REG_BASE_HEIGHT, {6'($urandom), window_base()});
    write_reg(mwg_pkg::REG_MIN_SCALE, {2'($urandom), lo});
    write_reg(mwg_pkg::REG_MAX_SCALE, {2'($urandom), hi});
    write_reg(mwg_pkg::REG_SCALE_STEP, {2'($urandom), mul});
    if ($urandom_range(0, 3) != 0) write_reg(mwg_pkg::REG_STRIDE, CfgDataW'($urandom));
  endtask

  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    window_t want;
    window_t got;
    if (rst_n && out_valid && out_ready) begin
      got.x = out_win_x;
      got.y = out_win_y;
      got.w = out_win_w;
      got.h = out_win_h;
      got.st = mwg_pkg::win_status_t'(out_status);
      got.last = out_last;
      if (window_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result beat: x=%0d y=%0d w=%0d h=%0d status=%0d last=%0d",
                   got.x, got.y, got.w, got.h, out_status, got.last);
      end else begin
        want = window_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Window mismatch: expected x=%0d y=%0d w=%0d h=%0d status=%0d last=%0d",
                     want.x, want.y, want.w, want.h, want.st, want.last);
            $display("                 got      x=%0d y=%0d w=%0d h=%0d status=%0d last=%0d",
                     got.x, got.y, got.w, got.h, out_status, got.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    plan_row_t plan[$];
    window_t   guess;
    int        sent;
    int        quota;
    int        burst;
    logic      held;
    sent = 0;
    quota = 0;
    held = 1'b0;
    plan = '{
      req_is(1'b0, 0, 0, 0, 0, mwg_pkg::WS_NONE, 1'b0),
      req_is(1'b1, 0, 0, 64, 128, mwg_pkg::WS_VALID, 1'b0),
      req_is(1'b0, 32, 0, 64, 128, mwg_pkg::WS_VALID, 1'b0),
      cfg_row(mwg_pkg::REG_IMAGE_WIDTH, 10),
      cfg_row(mwg_pkg::REG_IMAGE_HEIGHT, 10),
      cfg_row(mwg_pkg::REG_BASE_WIDTH, 4),
      cfg_row(mwg_pkg::REG_BASE_HEIGHT, 4),
      cfg_row(mwg_pkg::REG_MAX_SCALE, 300),
      cfg_row(mwg_pkg::REG_SCALE_STEP, 512),
      cfg_row(mwg_pkg::REG_STRIDE, 131328),
      req_is(1'b1, 0, 0, 4, 4, mwg_pkg::WS_VALID, 1'b0),
      req_is(1'b0, 4, 0, 4, 4, mwg_pkg::WS_VALID, 1'b0),
      req_is(1'b0, 0, 4, 4, 4, mwg_pkg::WS_VALID, 1'b0),
      req_is(1'b0, 4, 4, 4, 4, mwg_pkg::WS_VALID, 1'b1),
      req_is(1'b0, 0, 0, 0, 0, mwg_pkg::WS_DONE, 1'b0),
      req_is(1'b0, 0, 0, 0, 0, mwg_pkg::WS_DONE, 1'b0),
      cfg_row(mwg_pkg::REG_MIN_SCALE, 300),
      req_is(1'b1, 0, 0, 0, 0, mwg_pkg::WS_NONE, 1'b0),
      req_is(1'b0, 0, 0, 0, 0, mwg_pkg::WS_NONE, 1'b0),
      cfg_row(mwg_pkg::REG_STRIDE, 0),
      cfg_row(mwg_pkg::REG_MIN_SCALE, 0),
      cfg_row(mwg_pkg::REG_MAX_SCALE, 3),
      cfg_row(mwg_pkg::REG_SCALE_STEP, 0),
      cfg_row(mwg_pkg::REG_BASE_WIDTH, 0),
      cfg_row(mwg_pkg::REG_IMAGE_WIDTH, 3),
      cfg_row(mwg_pkg::REG_IMAGE_HEIGHT, 2),
      req(1'b1), req(1'b0), req(1'b0), req(1'b0), req(1'b0), req(1'b0), req(1'b0),
      cfg_row(mwg_pkg::REG_IMAGE_WIDTH, 4095),
      cfg_row(mwg_pkg::REG_IMAGE_HEIGHT, 4095),
      cfg_row(mwg_pkg::REG_BASE_WIDTH, 1),
      cfg_row(mwg_pkg::REG_BASE_HEIGHT, 1),
      cfg_row(mwg_pkg::REG_MIN_SCALE, 65534),
      cfg_row(mwg_pkg::REG_MAX_SCALE, 65535),
      cfg_row(mwg_pkg::REG_SCALE_STEP, 65535),
      cfg_row(mwg_pkg::REG_STRIDE, 262143),
      req_is(1'b1, 0, 0, 255, 255, mwg_pkg::WS_VALID, 1'b0),
      req(1'b0),
      cfg_row(mwg_pkg::REG_BASE_HEIGHT, 4095),
      req_is(1'b1, 0, 0, 0, 0, mwg_pkg::WS_NONE, 1'b0)
    };

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_item(plan[i].restart, guess);
        window_q.insert(window_q.size(), plan[i].typed ? plan[i].want : guess);
      end
    end

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle = 33;
          recv_idle = 79;
        end
        1: begin
          send_idle = 79;
          recv_idle = 33;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      quota += PhaseItems;
      while (sent < quota) begin
        pick_setting();
        burst = $urandom_range(20, 60);
        for (int k = 0; k < burst; k++) begin
          send_item((k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 15) == 0),
                    guess);
          window_q.insert(window_q.size(), guess);
          sent++;
        end
        if (!held) begin
          // The result side stops taking beats while requests keep coming,
          // so the block backs up and drops in_ready.
          held = 1'b1;
          hold_asks++;
          send_idle = 0;
          for (int k = 0; k < 8; k++) begin
            send_item(k == 0, guess);
            window_q.insert(window_q.size(), guess);
            sent++;
          end
          send_idle = 33;
        end
      end
    end

    settle();
    repeat (TailCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
